### src/tpp_pkg.sv
// Shared types and constants of the trapezoid profile planner.
// No dependencies; the channels, the top level and the testbench refer to it by scoped names.
`default_nettype none

package tpp_pkg;

  localparam int DATA_W = 32;   // signed Q fields
  localparam int REG_W  = 31;   // unsigned configuration registers
  localparam int IDX_W  = 1;    // configuration register index
  localparam int XW     = 72;   // exact intermediate sums

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_MAX_ACCEL = 1'b0;
  localparam logic [IDX_W-1:0] REG_MAX_VEL   = 1'b1;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [XW-1:0]     wide_t;

  // request as it travels through the square root
  typedef struct packed {
    data_t              t0;
    data_t              p0;
    data_t              v0;
    data_t              v1;
    logic signed [33:0] goal_d;
    logic               err;
  } req_t;

  // request plus cruise velocity, through the interval dividers
  typedef struct packed {
    req_t             req;
    logic [REG_W-1:0] cruise;
    logic             neg_a;
    logic             neg_d;
  } plan_t;

  // segment breakpoints, filled in stage by stage
  typedef struct packed {
    data_t              t0;
    data_t              p0;
    logic [REG_W-1:0]   cruise;
    data_t              a_int;
    data_t              d_int;
    logic signed [33:0] goal_d;
    wide_t              pa;
    wide_t              pd;
    wide_t              a_dist;
    wide_t              d_dist;
    wide_t              c_dist;
    wide_t              t_acc;
    wide_t              p_acc;
    wide_t              t_cr;
    wide_t              p_cr;
    wide_t              t_end;
    wide_t              p_end;
    logic               is_tri;
    logic               err;
    logic               neg_c;
  } seg_t;

  // result item
  typedef struct packed {
    data_t            accel_end_time;
    data_t            accel_end_pos;
    data_t            cruise_velocity;
    data_t            cruise_end_time;
    data_t            cruise_end_pos;
    data_t            final_time;
    data_t            final_pos;
    data_t            total_time;
    logic [REG_W-1:0] total_dist;
    logic             is_triangular;
    logic             plan_error;
  } res_t;

endpackage

`default_nettype wire

### src/tpp_ifs.sv
// Handshake channels of the trapezoid profile planner: move request and plan.
// Depends on tpp_pkg for the field widths.
`default_nettype none

interface tpp_in_if;
  logic                valid;
  logic                ready;
  tpp_pkg::data_t      start_time;
  tpp_pkg::data_t      start_pos;
  tpp_pkg::data_t      start_vel;
  tpp_pkg::data_t      end_pos;
  tpp_pkg::data_t      end_vel;

  modport source (output valid, start_time, start_pos, start_vel, end_pos, end_vel,
                  input ready);
  modport sink   (input valid, start_time, start_pos, start_vel, end_pos, end_vel,
                  output ready);
endinterface

interface tpp_out_if;
  logic                        valid;
  logic                        ready;
  tpp_pkg::data_t              accel_end_time;
  tpp_pkg::data_t              accel_end_pos;
  tpp_pkg::data_t              cruise_velocity;
  tpp_pkg::data_t              cruise_end_time;
  tpp_pkg::data_t              cruise_end_pos;
  tpp_pkg::data_t              final_time;
  tpp_pkg::data_t              final_pos;
  tpp_pkg::data_t              total_time;
  logic [tpp_pkg::REG_W-1:0]   total_dist;
  logic                        is_triangular;
  logic                        plan_error;

  modport source (output valid, accel_end_time, accel_end_pos, cruise_velocity,
                  cruise_end_time, cruise_end_pos, final_time, final_pos, total_time,
                  total_dist, is_triangular, plan_error, input ready);
  modport sink   (input valid, accel_end_time, accel_end_pos, cruise_velocity,
                  cruise_end_time, cruise_end_pos, final_time, final_pos, total_time,
                  total_dist, is_triangular, plan_error, output ready);
endinterface

`default_nettype wire

### src/tpp_sqrt.sv
// Pipelined integer square root of a 64-bit radicand, one root bit per stage.
// Stand-alone; carries a sideband vector alongside each item.
`default_nettype none

module tpp_sqrt #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [63:0]       in_rad,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [31:0]       out_root,
  output logic [SIDE_W-1:0] out_side
);

  localparam int STAGES = 32;

  logic              v_r    [1:STAGES];
  logic [SIDE_W-1:0] side_r [1:STAGES];
  logic [31:0]       root_r [1:STAGES];
  logic [33:0]       rem_r  [1:STAGES-1];
  logic [63:0]       rad_r  [1:STAGES-1];

  logic [33:0] rem_nxt  [1:STAGES];
  logic [31:0] root_nxt [1:STAGES];

  // one restoring step per stage
  always_comb begin
    logic [33:0] rem_p;
    logic [31:0] root_p;
    logic [63:0] rad_p;
    logic [35:0] rem2;
    logic [35:0] trial;
    logic        ge;
    for (int k = 1; k <= STAGES; k++) begin
      if (k == 1) begin
        rem_p  = '0;
        root_p = '0;
        rad_p  = in_rad;
      end else begin
        rem_p  = rem_r[k-1];
        root_p = root_r[k-1];
        rad_p  = rad_r[k-1];
      end
      rem2  = {rem_p, rad_p[63:62]};
      trial = {2'b00, root_p, 2'b01};
      ge    = rem2 >= trial;
      rem_nxt[k]  = ge ? 34'(rem2 - trial) : rem2[33:0];
      root_nxt[k] = {root_p[30:0], ge};
    end
  end

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= STAGES; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[1] <= in_valid;
      for (int k = 2; k <= STAGES; k++) v_r[k] <= v_r[k-1];
    end
  end

  // advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[1] <= in_side;
      for (int k = 2; k <= STAGES; k++) side_r[k] <= side_r[k-1];
      for (int k = 1; k <= STAGES; k++) root_r[k] <= root_nxt[k];
      for (int k = 1; k < STAGES; k++) rem_r[k] <= rem_nxt[k];
      rad_r[1] <= {in_rad[61:0], 2'b00};
      for (int k = 2; k < STAGES; k++) rad_r[k] <= {rad_r[k-1][61:0], 2'b00};
    end
  end

  assign out_valid = v_r[STAGES];
  assign out_root  = root_r[STAGES];
  assign out_side  = side_r[STAGES];

endmodule

`default_nettype wire

### src/tpp_div.sv
// Pipelined unsigned divider, one quotient bit per stage, lanes share a divisor.
// Flags quotients that do not fit Q_W bits. Stand-alone; carries a sideband.
`default_nettype none

module tpp_div #(
  parameter int LANES  = 1,
  parameter int NUM_W  = 48,
  parameter int DEN_W  = 31,
  parameter int Q_W    = 31,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  in_num [LANES],
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [Q_W-1:0]    out_q [LANES],
  output logic              out_ovf [LANES],
  output logic [SIDE_W-1:0] out_side
);

  localparam int HI_W = NUM_W - Q_W;
  localparam int CW   = (HI_W > DEN_W) ? HI_W : DEN_W;

  logic              v_r    [0:Q_W];
  logic [SIDE_W-1:0] side_r [0:Q_W];
  logic              ovf_r  [0:Q_W][LANES];
  logic [Q_W-1:0]    lq_r   [0:Q_W][LANES];
  logic [DEN_W-1:0]  rem_r  [0:Q_W-1][LANES];
  logic [DEN_W-1:0]  den_r  [0:Q_W-1];

  logic             ovf0_nxt [LANES];
  logic [DEN_W-1:0] rem0_nxt [LANES];
  logic [DEN_W:0]   rem_nxt  [1:Q_W][LANES];
  logic [Q_W-1:0]   lq_nxt   [1:Q_W][LANES];

  // setup: test for overflow, seed the partial remainder with the high bits
  always_comb begin
    logic [CW-1:0] hi;
    for (int l = 0; l < LANES; l++) begin
      hi          = CW'(in_num[l][NUM_W-1:Q_W]);
      ovf0_nxt[l] = hi >= CW'(in_den);
      rem0_nxt[l] = ovf0_nxt[l] ? '0 : DEN_W'(hi);
    end
  end

  // one compare and subtract per stage; quotient bits shift in below the numerator
  always_comb begin
    logic [DEN_W:0] rem2;
    logic           ge;
    for (int k = 1; k <= Q_W; k++) begin
      for (int l = 0; l < LANES; l++) begin
        rem2 = {rem_r[k-1][l], lq_r[k-1][l][Q_W-1]};
        ge   = rem2 >= {1'b0, den_r[k-1]};
        rem_nxt[k][l] = ge ? (rem2 - {1'b0, den_r[k-1]}) : rem2;
        lq_nxt[k][l]  = {lq_r[k-1][l][Q_W-2:0], ge};
      end
    end
  end

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= Q_W; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int k = 1; k <= Q_W; k++) v_r[k] <= v_r[k-1];
    end
  end

  // advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      den_r[0]  <= in_den;
      for (int l = 0; l < LANES; l++) begin
        ovf_r[0][l] <= ovf0_nxt[l];
        rem_r[0][l] <= rem0_nxt[l];
        lq_r[0][l]  <= in_num[l][Q_W-1:0];
      end
      for (int k = 1; k <= Q_W; k++) begin
        side_r[k] <= side_r[k-1];
        for (int l = 0; l < LANES; l++) begin
          ovf_r[k][l] <= ovf_r[k-1][l];
          lq_r[k][l]  <= lq_nxt[k][l];
        end
      end
      for (int k = 1; k < Q_W; k++) begin
        den_r[k] <= den_r[k-1];
        for (int l = 0; l < LANES; l++) rem_r[k][l] <= rem_nxt[k][l][DEN_W-1:0];
      end
    end
  end

  assign out_valid = v_r[Q_W];
  assign out_side  = side_r[Q_W];
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      out_q[l]   = lq_r[Q_W][l];
      out_ovf[l] = ovf_r[Q_W][l];
    end
  end

endmodule

`default_nettype wire

### src/trapezoid_profile_planner.sv
// Trapezoid velocity profile planner, top level.
// Depends on tpp_pkg, tpp_ifs (channels), tpp_sqrt and tpp_div.
//
// Usage:
//   in_req  : move request (start time, position, velocity, goal position, velocity).
//   out_res : segment breakpoints of accelerate, cruise and decelerate, saturated.
//   cfg_*   : write port for max_accel (index 0) and max_vel (index 1); write only
//             while no item is in flight.
// From acceptance to the result on out_res, an item passes the subtract and
//   multiply stages, 32 square root stages, 1 cap stage, the interval division
//   stages, the distance arithmetic stages, the cruise interval division stages
//   and 3 summing and saturating stages.
// Throughput is one item per cycle while out_res takes its results; every stage holds
// one item and the dividers and root resolve one bit per stage.
// The whole pipeline advances together: while out_res holds a result that is not
// taken, every stage holds and in_req.ready is low; nothing is lost or repeated.
// Reset (rst_n low at a clock edge) clears all valid bits and sets both
// registers to 1.0.
`default_nettype none

module trapezoid_profile_planner #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  tpp_in_if.sink                              in_req,
  tpp_out_if.source                           out_res,
  input  logic                                cfg_we,
  input  logic [tpp_pkg::IDX_W-1:0]           cfg_index,
  input  logic [tpp_pkg::REG_W-1:0]           cfg_data
);

  localparam int NUM_W = tpp_pkg::DATA_W + FRAC_BITS;
  localparam int AQ_W  = 31;   // interval quotient bits before saturation
  localparam int CQ_W  = 34;   // cruise interval bits before clamping
  localparam int SH    = FRAC_BITS + 1;

  localparam tpp_pkg::wide_t MAX32 = 72'sd2147483647;
  localparam tpp_pkg::wide_t MIN32 = -72'sd2147483648;
  localparam tpp_pkg::wide_t MAX31 = 72'sd2147483647;
  localparam tpp_pkg::wide_t BIAS  = (tpp_pkg::wide_t'(1) <<< SH) - tpp_pkg::wide_t'(1);

  function automatic tpp_pkg::data_t sat32(input tpp_pkg::wide_t x);
    if (x > MAX32)      sat32 = 32'sh7fffffff;
    else if (x < MIN32) sat32 = 32'sh80000000;
    else                sat32 = x[31:0];
  endfunction

  // saturate an interval magnitude with its sign
  function automatic tpp_pkg::data_t sat_int(input logic [AQ_W-1:0] q, input logic ovf,
                                             input logic neg);
    if (ovf) sat_int = neg ? 32'sh80000000 : 32'sh7fffffff;
    else     sat_int = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

  // divide by 2^(FRAC_BITS+1), truncating toward zero
  function automatic tpp_pkg::wide_t half_scale(input tpp_pkg::wide_t x);
    half_scale = (x + (x[tpp_pkg::XW-1] ? BIAS : tpp_pkg::wide_t'(0))) >>> SH;
  endfunction

  // ---------------- configuration ----------------
  logic [tpp_pkg::REG_W-1:0] max_accel_r, max_vel_r, acc_eff;

  // take register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_accel_r <= 31'd65536;
      max_vel_r   <= 31'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tpp_pkg::REG_MAX_ACCEL: max_accel_r <= cfg_data;
        tpp_pkg::REG_MAX_VEL:   max_vel_r   <= cfg_data;
      endcase
    end
  end

  // zero acceleration acts as the smallest step
  assign acc_eff = (max_accel_r == '0) ? 31'd1 : max_accel_r;

  // ---------------- pipeline control ----------------
  logic en;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, v9_r, out_valid_r;
  logic sq_valid, ad_valid, dc_valid;

  assign en           = !out_valid_r || out_res.ready;
  assign in_req.ready = en;

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0; v5_r <= 1'b0;
      v6_r <= 1'b0; v7_r <= 1'b0; v8_r <= 1'b0; v9_r <= 1'b0; out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_req.valid;
      v2_r <= v1_r;
      v3_r <= sq_valid;
      v4_r <= ad_valid;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= dc_valid;
      v9_r <= v8_r;
      out_valid_r <= v9_r;
    end
  end

  // ---------------- stage 1: goal distance ----------------
  tpp_pkg::req_t req1_nxt, req1_r, req2_r;

  always_comb begin
    req1_nxt.t0     = in_req.start_time;
    req1_nxt.p0     = in_req.start_pos;
    req1_nxt.v0     = in_req.start_vel;
    req1_nxt.v1     = in_req.end_vel;
    req1_nxt.goal_d = 34'(in_req.end_pos) - 34'(in_req.start_pos);
    req1_nxt.err    = req1_nxt.goal_d[33];
  end

  always_ff @(posedge clk) begin
    if (en) req1_r <= req1_nxt;
  end

  // ---------------- stage 2: radicand ----------------
  logic [31:0] dist_u;
  logic [62:0] prod_nxt, prod_r;

  assign dist_u   = req1_r.err ? 32'd0 : req1_r.goal_d[31:0];
  assign prod_nxt = dist_u * acc_eff;

  always_ff @(posedge clk) begin
    if (en) begin
      req2_r <= req1_r;
      prod_r <= prod_nxt;
    end
  end

  // ---------------- square root ----------------
  logic [31:0]   sq_root;
  tpp_pkg::req_t sq_side;

  tpp_sqrt #(
    .SIDE_W ($bits(tpp_pkg::req_t))
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v2_r),
    .in_rad    ({1'b0, prod_r}),
    .in_side   (req2_r),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // ---------------- stage 3: cap and interval numerators ----------------
  tpp_pkg::plan_t     plan3_nxt, plan3_r;
  logic signed [33:0] na, nd;
  logic [31:0]        na_mag, nd_mag, na3_r, nd3_r;

  always_comb begin
    plan3_nxt.req    = sq_side;
    plan3_nxt.cruise = (sq_root > {1'b0, max_vel_r}) ? max_vel_r : sq_root[30:0];
    na = $signed({3'b000, plan3_nxt.cruise}) - 34'(sq_side.v0);
    nd = $signed({3'b000, plan3_nxt.cruise}) - 34'(sq_side.v1);
    plan3_nxt.neg_a = na[33];
    plan3_nxt.neg_d = nd[33];
    na_mag = na[33] ? 32'(-na) : na[31:0];
    nd_mag = nd[33] ? 32'(-nd) : nd[31:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      plan3_r <= plan3_nxt;
      na3_r   <= na_mag;
      nd3_r   <= nd_mag;
    end
  end

  // ---------------- accel and decel intervals ----------------
  logic [NUM_W-1:0] ad_num [2];
  logic [AQ_W-1:0]  ad_q   [2];
  logic             ad_ovf [2];
  tpp_pkg::plan_t   ad_side;

  assign ad_num[0] = {na3_r, {FRAC_BITS{1'b0}}};
  assign ad_num[1] = {nd3_r, {FRAC_BITS{1'b0}}};

  tpp_div #(
    .LANES  (2),
    .NUM_W  (NUM_W),
    .DEN_W  (tpp_pkg::REG_W),
    .Q_W    (AQ_W),
    .SIDE_W ($bits(tpp_pkg::plan_t))
  ) u_div_ad (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v3_r),
    .in_num    (ad_num),
    .in_den    (acc_eff),
    .in_side   (plan3_r),
    .out_valid (ad_valid),
    .out_q     (ad_q),
    .out_ovf   (ad_ovf),
    .out_side  (ad_side)
  );

  // ---------------- stage 4: saturate intervals, distance products ----------------
  tpp_pkg::seg_t      seg4_nxt, seg4_r, seg5_r, seg6_r, seg7_r;
  logic signed [33:0] vsum_a, vsum_d;
  logic signed [65:0] pa, pd;

  always_comb begin
    seg4_nxt        = '0;
    seg4_nxt.t0     = ad_side.req.t0;
    seg4_nxt.p0     = ad_side.req.p0;
    seg4_nxt.goal_d = ad_side.req.goal_d;
    seg4_nxt.err    = ad_side.req.err;
    seg4_nxt.cruise = ad_side.cruise;
    seg4_nxt.a_int  = sat_int(ad_q[0], ad_ovf[0], ad_side.neg_a);
    seg4_nxt.d_int  = sat_int(ad_q[1], ad_ovf[1], ad_side.neg_d);
    vsum_a = 34'(ad_side.req.v0) + $signed({3'b000, ad_side.cruise});
    vsum_d = 34'(ad_side.req.v1) + $signed({3'b000, ad_side.cruise});
    pa = vsum_a * seg4_nxt.a_int;
    pd = vsum_d * seg4_nxt.d_int;
    seg4_nxt.pa = tpp_pkg::XW'(pa);
    seg4_nxt.pd = tpp_pkg::XW'(pd);
  end

  always_ff @(posedge clk) begin
    if (en) seg4_r <= seg4_nxt;
  end

  // ---------------- stage 5: accel and decel distances ----------------
  tpp_pkg::seg_t seg5_nxt;

  always_comb begin
    seg5_nxt        = seg4_r;
    seg5_nxt.a_dist = half_scale(seg4_r.pa);
    seg5_nxt.d_dist = half_scale(seg4_r.pd);
  end

  always_ff @(posedge clk) begin
    if (en) seg5_r <= seg5_nxt;
  end

  // ---------------- stage 6: cruise distance, accel breakpoint ----------------
  tpp_pkg::seg_t seg6_nxt;

  always_comb begin
    seg6_nxt        = seg5_r;
    seg6_nxt.c_dist = tpp_pkg::XW'(seg5_r.goal_d) - seg5_r.a_dist - seg5_r.d_dist;
    seg6_nxt.t_acc  = tpp_pkg::XW'(seg5_r.t0) + tpp_pkg::XW'(seg5_r.a_int);
    seg6_nxt.p_acc  = tpp_pkg::XW'(seg5_r.p0) + seg5_r.a_dist;
  end

  always_ff @(posedge clk) begin
    if (en) seg6_r <= seg6_nxt;
  end

  // ---------------- stage 7: triangle test, cruise numerator ----------------
  tpp_pkg::seg_t  seg7_nxt;
  tpp_pkg::data_t c_sat;
  logic [31:0]    c_mag, c_mag7_r;

  always_comb begin
    seg7_nxt        = seg6_r;
    seg7_nxt.is_tri = (seg6_r.c_dist == '0);
    seg7_nxt.err    = seg6_r.err || (!seg7_nxt.is_tri && seg6_r.cruise == '0);
    c_sat           = sat32(seg6_r.c_dist);
    seg7_nxt.neg_c  = c_sat[31];
    c_mag           = c_sat[31] ? 32'(-33'(c_sat)) : c_sat;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      seg7_r   <= seg7_nxt;
      c_mag7_r <= c_mag;
    end
  end

  // ---------------- cruise interval ----------------
  logic [NUM_W-1:0] c_num  [1];
  logic [CQ_W-1:0]  c_q    [1];
  logic             c_ovf  [1];
  tpp_pkg::seg_t    dc_side;

  assign c_num[0] = {c_mag7_r, {FRAC_BITS{1'b0}}};

  tpp_div #(
    .LANES  (1),
    .NUM_W  (NUM_W),
    .DEN_W  (tpp_pkg::REG_W),
    .Q_W    (CQ_W),
    .SIDE_W ($bits(tpp_pkg::seg_t))
  ) u_div_c (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v7_r),
    .in_num    (c_num),
    .in_den    (seg7_r.cruise),
    .in_side   (seg7_r),
    .out_valid (dc_valid),
    .out_q     (c_q),
    .out_ovf   (c_ovf),
    .out_side  (dc_side)
  );

  // ---------------- stage 8: cruise breakpoint ----------------
  tpp_pkg::seg_t  seg8_nxt, seg8_r, seg9_nxt, seg9_r;
  logic [CQ_W:0]  qc;
  tpp_pkg::wide_t qs;

  always_comb begin
    // a clamped interval already pushes every later time past saturation
    qc = c_ovf[0] ? {1'b1, {CQ_W{1'b0}}} : {1'b0, c_q[0]};
    qs = dc_side.neg_c ? -tpp_pkg::XW'(qc) : tpp_pkg::XW'(qc);
    seg8_nxt      = dc_side;
    seg8_nxt.t_cr = dc_side.is_tri ? dc_side.t_acc : dc_side.t_acc + qs;
    seg8_nxt.p_cr = dc_side.is_tri ? dc_side.p_acc : dc_side.p_acc + dc_side.c_dist;
  end

  always_ff @(posedge clk) begin
    if (en) seg8_r <= seg8_nxt;
  end

  // ---------------- stage 9: final breakpoint ----------------
  always_comb begin
    seg9_nxt       = seg8_r;
    seg9_nxt.t_end = seg8_r.t_cr + tpp_pkg::XW'(seg8_r.d_int);
    seg9_nxt.p_end = seg8_r.p_cr + seg8_r.d_dist;
  end

  always_ff @(posedge clk) begin
    if (en) seg9_r <= seg9_nxt;
  end

  // ---------------- stage 10: saturate into the output register ----------------
  tpp_pkg::res_t  res_nxt, res_r;
  tpp_pkg::wide_t tot_d;

  always_comb begin
    tot_d = seg9_r.p_end - tpp_pkg::XW'(seg9_r.p0);
    if (tot_d[tpp_pkg::XW-1]) tot_d = -tot_d;
    res_nxt = '0;
    if (seg9_r.err) begin
      res_nxt.plan_error = 1'b1;
    end else begin
      res_nxt.accel_end_time  = sat32(seg9_r.t_acc);
      res_nxt.accel_end_pos   = sat32(seg9_r.p_acc);
      res_nxt.cruise_velocity = {1'b0, seg9_r.cruise};
      res_nxt.cruise_end_time = sat32(seg9_r.t_cr);
      res_nxt.cruise_end_pos  = sat32(seg9_r.p_cr);
      res_nxt.final_time      = sat32(seg9_r.t_end);
      res_nxt.final_pos       = sat32(seg9_r.p_end);
      res_nxt.total_time      = sat32(seg9_r.t_end - tpp_pkg::XW'(seg9_r.t0));
      res_nxt.total_dist      = (tot_d > MAX31) ? 31'h7fffffff : tot_d[30:0];
      res_nxt.is_triangular   = seg9_r.is_tri;
    end
  end

  always_ff @(posedge clk) begin
    if (en) res_r <= res_nxt;
  end

  // drive the result channel
  assign out_res.valid           = out_valid_r;
  assign out_res.accel_end_time  = res_r.accel_end_time;
  assign out_res.accel_end_pos   = res_r.accel_end_pos;
  assign out_res.cruise_velocity = res_r.cruise_velocity;
  assign out_res.cruise_end_time = res_r.cruise_end_time;
  assign out_res.cruise_end_pos  = res_r.cruise_end_pos;
  assign out_res.final_time      = res_r.final_time;
  assign out_res.final_pos       = res_r.final_pos;
  assign out_res.total_time      = res_r.total_time;
  assign out_res.total_dist      = res_r.total_dist;
  assign out_res.is_triangular   = res_r.is_triangular;
  assign out_res.plan_error      = res_r.plan_error;

  // ---------------- assertions ----------------
  // a failed plan carries nothing but the error flag
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.plan_error |->
      out_res.cruise_velocity == '0 && out_res.total_dist == '0 &&
      out_res.final_time == '0 && !out_res.is_triangular)
    else $error("plan error with nonzero fields");

  // a triangular profile has no cruise segment
  a_tri_flat: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.is_triangular |->
      out_res.cruise_end_time == out_res.accel_end_time &&
      out_res.cruise_end_pos == out_res.accel_end_pos)
    else $error("triangular profile with cruise segment");

  // cruise velocity is never negative
  a_cruise_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> !out_res.cruise_velocity[31])
    else $error("negative cruise velocity");

endmodule

`default_nettype wire

### tb/trapezoid_profile_planner_tb.sv
// Testbench for the trapezoid profile planner: drives move requests, checks each plan
// against a bit-exact predictor, and rewrites the limits between phases.
// Depends on tpp_pkg, tpp_ifs and the planner RTL.
`timescale 1ns / 100ps

class plan_scoreboard;
  tpp_pkg::res_t pending_plans[$];
  int            n_errors;

  function new();
    n_errors = 0;
  endfunction

  // note the plan expected for one accepted request
  function void note_request(tpp_pkg::res_t plan);
    pending_plans.insert(pending_plans.size(), plan);
  endfunction

  function void report(string field, logic [31:0] want, logic [31:0] got);
    $display("%0t: %s expected %h actual %h", $time, field, want, got);
    n_errors++;
  endfunction

  // compare one accepted plan with the oldest expectation
  function void check_plan(tpp_pkg::res_t got);
    tpp_pkg::res_t want;
    if (pending_plans.size() == 0) begin
      $display("%0t: unexpected plan %h", $time, got);
      n_errors++;
      return;
    end
    want = pending_plans.pop_front();
    if (got.accel_end_time !== want.accel_end_time)
      report("accel_end_time", want.accel_end_time, got.accel_end_time);
    if (got.accel_end_pos !== want.accel_end_pos)
      report("accel_end_pos", want.accel_end_pos, got.accel_end_pos);
    if (got.cruise_velocity !== want.cruise_velocity)
      report("cruise_velocity", want.cruise_velocity, got.cruise_velocity);
    if (got.cruise_end_time !== want.cruise_end_time)
      report("cruise_end_time", want.cruise_end_time, got.cruise_end_time);
    if (got.cruise_end_pos !== want.cruise_end_pos)
      report("cruise_end_pos", want.cruise_end_pos, got.cruise_end_pos);
    if (got.final_time !== want.final_time)
      report("final_time", want.final_time, got.final_time);
    if (got.final_pos !== want.final_pos)
      report("final_pos", want.final_pos, got.final_pos);
    if (got.total_time !== want.total_time)
      report("total_time", want.total_time, got.total_time);
    if (got.total_dist !== want.total_dist)
      report("total_dist", 32'(want.total_dist), 32'(got.total_dist));
    if (got.is_triangular !== want.is_triangular)
      report("is_triangular", 32'(want.is_triangular), 32'(got.is_triangular));
    if (got.plan_error !== want.plan_error)
      report("plan_error", 32'(want.plan_error), 32'(got.plan_error));
  endfunction
endclass

module trapezoid_profile_planner_tb;

  localparam int FRAC     = 16;
  localparam int LATENCY  = 109;
  localparam int WATCHDOG = 20000;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [tpp_pkg::IDX_W-1:0] cfg_index = tpp_pkg::REG_MAX_ACCEL;
  logic [tpp_pkg::REG_W-1:0] cfg_data = '0;

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  quiet_cycles = 0;

  logic [tpp_pkg::REG_W-1:0] accel_limit = 65536;
  logic [tpp_pkg::REG_W-1:0] vel_limit   = 65536;

  plan_scoreboard sb = new();

  tpp_in_if  in_req();
  tpp_out_if out_res();

  trapezoid_profile_planner #(.FRAC_BITS(FRAC)) u_dut (
    .clk(clk), .rst_n(rst_n), .in_req(in_req), .out_res(out_res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // exact floor square root of a 64-bit value
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // work out the plan for one move request under the current limits
  function automatic tpp_pkg::res_t plan_move(tpp_pkg::data_t t0i, tpp_pkg::data_t p0i,
                                              tpp_pkg::data_t v0i, tpp_pkg::data_t p1i,
                                              tpp_pkg::data_t v1i);
    tpp_pkg::res_t r;
    longint one, t0, p0, v0, p1, v1, acc, goal_d, cruise, a_int, d_int;
    longint a_dist, d_dist, c_dist, t_acc, p_acc, t_cr, p_cr, t_end, p_end, tot_d;
    bit     tri_seg;
    r = '0;
    one = longint'(1) << FRAC;
    t0 = longint'(t0i); p0 = longint'(p0i); v0 = longint'(v0i);
    p1 = longint'(p1i); v1 = longint'(v1i);
    acc = (accel_limit == 0) ? longint'(1) : longint'(accel_limit);
    goal_d = p1 - p0;
    if (goal_d < 0) begin
      r.plan_error = 1'b1;
      return r;
    end
    cruise = longint'(floor_sqrt(longint'(unsigned'(goal_d)) * longint'(unsigned'(acc))));
    if (cruise > longint'(vel_limit)) cruise = longint'(vel_limit);
    a_int = clamp32(((cruise - v0) * one) / acc);
    d_int = clamp32(((cruise - v1) * one) / acc);
    a_dist = ((v0 + cruise) * a_int) / (2 * one);
    d_dist = ((cruise + v1) * d_int) / (2 * one);
    c_dist = goal_d - a_dist - d_dist;
    t_acc = t0 + a_int;
    p_acc = p0 + a_dist;
    tri_seg = (c_dist == 0);
    if (tri_seg) begin
      t_cr = t_acc;
      p_cr = p_acc;
    end else begin
      if (cruise == 0) begin
        r.plan_error = 1'b1;
        return r;
      end
      t_cr = t_acc + (clamp32(c_dist) * one) / cruise;
      p_cr = p_acc + c_dist;
    end
    t_end = t_cr + d_int;
    p_end = p_cr + d_dist;
    tot_d = p_end - p0;
    if (tot_d < 0) tot_d = -tot_d;
    if (tot_d > 64'sd2147483647) tot_d = 64'sd2147483647;
    r.accel_end_time  = 32'(clamp32(t_acc));
    r.accel_end_pos   = 32'(clamp32(p_acc));
    r.cruise_velocity = 32'(clamp32(cruise));
    r.cruise_end_time = 32'(clamp32(t_cr));
    r.cruise_end_pos  = 32'(clamp32(p_cr));
    r.final_time      = 32'(clamp32(t_end));
    r.final_pos       = 32'(clamp32(p_end));
    r.total_time      = 32'(clamp32(t_end - t0));
    r.total_dist      = tot_d[tpp_pkg::REG_W-1:0];
    r.is_triangular   = tri_seg;
    r.plan_error      = 1'b0;
    return r;
  endfunction

  // offer one request, hold it until taken and note its plan
  task automatic send_move(tpp_pkg::data_t t0, tpp_pkg::data_t p0, tpp_pkg::data_t v0,
                           tpp_pkg::data_t p1, tpp_pkg::data_t v1);
    while ($urandom_range(99) < send_idle_pct) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid      <= 1'b1;
    in_req.start_time <= t0;
    in_req.start_pos  <= p0;
    in_req.start_vel  <= v0;
    in_req.end_pos    <= p1;
    in_req.end_vel    <= v1;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    sb.note_request(plan_move(t0, p0, v0, p1, v1));
  endtask

  // write one limit register with the block idle
  task automatic write_limit(logic [tpp_pkg::IDX_W-1:0] idx,
                             logic [tpp_pkg::REG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == tpp_pkg::REG_MAX_ACCEL) accel_limit = val;
    else vel_limit = val;
    @(posedge clk);
  endtask

  task automatic drain();
    in_req.valid <= 1'b0;
    while (sb.pending_plans.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic tpp_pkg::data_t rand_word();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      2: return tpp_pkg::data_t'($urandom_range(1 << 20)) - (1 << 19);
      default: return tpp_pkg::data_t'($urandom_range(1 << 24));
    endcase
  endfunction

  // mostly well-formed moves; a few with goal behind start or wild values
  task automatic random_move();
    tpp_pkg::data_t p0, p1, d;
    p0 = tpp_pkg::data_t'($urandom_range(1 << 26)) - (1 << 25);
    case ($urandom_range(9))
      0: d = -tpp_pkg::data_t'($urandom_range(1 << 20) + 1);
      1: d = 0;
      2: d = rand_word();
      default: d = tpp_pkg::data_t'($urandom_range(1 << ($urandom_range(24) + 1)));
    endcase
    p1 = p0 + d;
    if ($urandom_range(7) == 0) p0 = rand_word();
    send_move(rand_word(), p0,
              $urandom_range(3) == 0 ? rand_word()
                                     : tpp_pkg::data_t'($urandom_range(1 << 17)),
              p1,
              $urandom_range(3) == 0 ? rand_word()
                                     : tpp_pkg::data_t'($urandom_range(1 << 17)));
  endtask

  // receiver: stall at random, check every plan taken
  always @(posedge clk) begin
    if (rst_n && out_res.valid && out_res.ready)
      sb.check_plan(tpp_pkg::res_t'{out_res.accel_end_time, out_res.accel_end_pos,
                                    out_res.cruise_velocity, out_res.cruise_end_time,
                                    out_res.cruise_end_pos, out_res.final_time,
                                    out_res.final_pos, out_res.total_time,
                                    out_res.total_dist, out_res.is_triangular,
                                    out_res.plan_error});
    out_res.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if ((in_req.valid && in_req.ready) || (out_res.valid && out_res.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    in_req.valid      <= 1'b0;
    in_req.start_time <= '0;
    in_req.start_pos  <= '0;
    in_req.start_vel  <= '0;
    in_req.end_pos    <= '0;
    in_req.end_vel    <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, triangular, cap reached, error cases
    send_move(0, 0, 0, 0, 0);
    send_move(0, 0, 0, 32'sh00010000, 0);
    send_move(0, 0, 0, 32'sh00100000, 0);
    send_move(100, 0, 32'sh00010000, 32'sh00040000, 32'sh00010000);
    send_move(0, 32'sh00010000, 0, 0, 0);
    send_move(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
    send_move(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
    send_move(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
    send_move(-1, -1, -1, -1, -1);
    send_move(0, 0, 32'sh00020000, 32'sh00008000, 32'sh00030000);
    drain();
    write_limit(tpp_pkg::REG_MAX_ACCEL, 0);
    write_limit(tpp_pkg::REG_MAX_VEL, 0);
    send_move(0, 0, 0, 0, 0);
    send_move(0, 0, 0, 5, 0);
    send_move(0, 0, 32'sh00010000, 32'sh00100000, -32'sh00010000);
    drain();
    write_limit(tpp_pkg::REG_MAX_ACCEL, 31'h7fffffff);
    write_limit(tpp_pkg::REG_MAX_VEL, 31'h7fffffff);
    send_move(0, 32'sh80000000, 0, 32'sh7fffffff, 0);
    send_move(5, 0, 0, 32'sh00010000, 0);
    send_move(32'sh7fff0000, 0, 32'sh80000000, 1, 32'sh80000000);
    drain();
    write_limit(tpp_pkg::REG_MAX_ACCEL, 1);
    write_limit(tpp_pkg::REG_MAX_VEL, 31'h7fffffff);
    send_move(0, 0, 0, 32'sh00000100, 0);
    send_move(0, 0, 32'sh7fffffff, 32'sh7fffffff, 0);
    drain();

    // random phases over several limit settings and idling patterns
    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: begin send_idle_pct = 12; recv_stall_pct = 71; end
        1: begin send_idle_pct = 71; recv_stall_pct = 12; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      write_limit(tpp_pkg::REG_MAX_ACCEL,
                  ph == 5 ? 31'h7fffffff : 31'($urandom_range(1 << 20, 1)));
      write_limit(tpp_pkg::REG_MAX_VEL,
                  ph == 4 ? 31'd1 : 31'($urandom_range(1 << 21, 1)));
      for (int k = 0; k < 240; k++) random_move();
      drain();
    end

    if (sb.n_errors == 0 && sb.pending_plans.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

### files.f
src/tpp_pkg.sv
src/tpp_ifs.sv
src/tpp_sqrt.sv
src/tpp_div.sv
src/trapezoid_profile_planner.sv
tb/trapezoid_profile_planner_tb.sv
